/* hdl/bdle_pkg.sv */
// ----------------------------------------------------------------------------
// Bounded deque list engine package
// Shared sizes, operation codes and status codes.
// ----------------------------------------------------------------------------
package bdle_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = 4;   // address bits of the entry store
  localparam int CNT_W    = 5;   // entry count, holds 0 to CAPACITY
  localparam int VAL_W    = 32;

  localparam logic [2:0] OP_PREPEND  = 3'd0;
  localparam logic [2:0] OP_APPEND   = 3'd1;
  localparam logic [2:0] OP_POP_HEAD = 3'd2;
  localparam logic [2:0] OP_POP_TAIL = 3'd3;
  localparam logic [2:0] OP_INS_AT   = 3'd4;
  localparam logic [2:0] OP_DEL_AT   = 3'd5;
  localparam logic [2:0] OP_DEL_VAL  = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

endpackage

/* hdl/bounded_deque_list_engine.sv */
// ----------------------------------------------------------------------------
// Bounded deque list engine
// Ordered list of signed 32-bit entries kept in one synchronous memory,
// with head and tail operations, positional insert and delete, and delete
// by value. Every input beat yields one result beat.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload (lowest bit up)
//  s_axis    in         opcode[2:0], value[34:3], position[42:35], zero pad
//  m_axis    out        status[1:0], popped_value[33:2], entry_count[38:34],
//                       list_empty[39]
//
// One beat at a time: a new beat is taken only once the last result has
// been placed in the output register. Shifts move one entry per cycle
// through the single memory port pair: inserts shift the entries at and above
// the position up, head pops and deletes shift the entries above it down.
// Reset clears the count and handshake, not the store; a waiting result is dropped.
module bounded_deque_list_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // opcode, value, position, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // status, popped_value, entry_count, list_empty
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_UP   = 3'd2;
  localparam logic [2:0] S_DN   = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]                   state_q, state_d;
  logic [bdle_pkg::CNT_W-1:0]   count_q, count_d;
  logic [bdle_pkg::IDX_W-1:0]   ptr_q, ptr_d;
  logic [bdle_pkg::IDX_W-1:0]   la_q, la_d;
  logic                         more_q, more_d;
  logic                         rv_q, rv_d;
  logic [2:0]                   op_q, op_d;
  logic [bdle_pkg::VAL_W-1:0]   val_q, val_d;
  logic [bdle_pkg::IDX_W-1:0]   p_q, p_d;
  logic [1:0]                   status_q, status_d;
  logic [bdle_pkg::VAL_W-1:0]   popped_q, popped_d;
  logic                         out_valid_q;
  logic [39:0]                  out_data_q;

  logic [bdle_pkg::VAL_W-1:0]   mem [bdle_pkg::CAPACITY];
  logic [bdle_pkg::VAL_W-1:0]   rdata_q;
  logic [bdle_pkg::IDX_W-1:0]   ra;
  logic                         we;
  logic [bdle_pkg::IDX_W-1:0]   wa;
  logic [bdle_pkg::VAL_W-1:0]   wd;

  logic [2:0]                   in_op;
  logic [bdle_pkg::VAL_W-1:0]   in_val;
  logic [7:0]                   in_pos;
  logic                         in_fire;
  logic [bdle_pkg::CNT_W-1:0]   last_idx;
  logic [bdle_pkg::IDX_W-1:0]   ins_p;
  logic                         is_pop;
  logic                         hit;

  assign in_op   = s_axis_tdata[2:0];
  assign in_val  = s_axis_tdata[34:3];
  assign in_pos  = s_axis_tdata[42:35];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign last_idx = count_q - bdle_pkg::CNT_W'(1);
  assign ins_p = (in_pos >= {3'b000, count_q}) ? count_q[bdle_pkg::IDX_W-1:0]
                                               : in_pos[bdle_pkg::IDX_W-1:0];
  assign is_pop = (op_q == bdle_pkg::OP_POP_HEAD) || (op_q == bdle_pkg::OP_POP_TAIL);
  assign hit = rv_q && (is_pop || (rdata_q == val_q));

  // Entry store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_q <= mem[ra];
  end

  // Sequencer: reads, shifts and writes back one entry per cycle.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    la_d     = la_q;
    more_d   = more_q;
    rv_d     = rv_q;
    op_d     = op_q;
    val_d    = val_q;
    p_d      = p_q;
    status_d = status_q;
    popped_d = popped_q;
    ra       = ptr_q;
    we       = 1'b0;
    wa       = p_q;
    wd       = val_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d     = in_op;
          val_d    = in_val;
          status_d = bdle_pkg::ST_OK;
          popped_d = '0;
          rv_d     = 1'b0;
          more_d   = 1'b1;
          state_d  = S_DONE;
          case (in_op)
            bdle_pkg::OP_PREPEND, bdle_pkg::OP_APPEND, bdle_pkg::OP_INS_AT: begin
              if (count_q == bdle_pkg::CNT_W'(bdle_pkg::CAPACITY)) begin
                status_d = bdle_pkg::ST_FULL;
              end else begin
                if (in_op == bdle_pkg::OP_PREPEND) begin
                  p_d = '0;
                end else if (in_op == bdle_pkg::OP_APPEND) begin
                  p_d = count_q[bdle_pkg::IDX_W-1:0];
                end else begin
                  p_d = ins_p;
                end
                ptr_d = last_idx[bdle_pkg::IDX_W-1:0];
                if ({1'b0, p_d} == count_q) begin
                  state_d = S_WR;
                end else begin
                  state_d = S_UP;
                end
              end
            end
            bdle_pkg::OP_POP_HEAD, bdle_pkg::OP_POP_TAIL: begin
              if (count_q == '0) begin
                status_d = bdle_pkg::ST_EMPTY;
              end else begin
                ptr_d   = (in_op == bdle_pkg::OP_POP_HEAD) ? '0
                          : last_idx[bdle_pkg::IDX_W-1:0];
                state_d = S_SCAN;
              end
            end
            bdle_pkg::OP_DEL_AT: begin
              if (in_pos >= {3'b000, count_q}) begin
                status_d = bdle_pkg::ST_NOTFOUND;
              end else if ({3'b000, last_idx} == in_pos) begin
                count_d = last_idx;
              end else begin
                ptr_d   = in_pos[bdle_pkg::IDX_W-1:0] + bdle_pkg::IDX_W'(1);
                state_d = S_DN;
              end
            end
            bdle_pkg::OP_DEL_VAL: begin
              if (count_q == '0) begin
                status_d = bdle_pkg::ST_NOTFOUND;
              end else begin
                ptr_d   = '0;
                state_d = S_SCAN;
              end
            end
            default: begin
              status_d = bdle_pkg::ST_OK;
            end
          endcase
        end
      end

      // Walk entries from ptr until a match or the tail.
      S_SCAN: begin
        if (hit) begin
          if (is_pop) begin
            popped_d = rdata_q;
          end
          if ((op_q == bdle_pkg::OP_POP_TAIL) || ({1'b0, la_q} == last_idx)) begin
            count_d = last_idx;
            state_d = S_DONE;
          end else begin
            ptr_d   = la_q + bdle_pkg::IDX_W'(1);
            more_d  = 1'b1;
            rv_d    = 1'b0;
            state_d = S_DN;
          end
        end else if (rv_q && ({1'b0, la_q} == last_idx)) begin
          status_d = bdle_pkg::ST_NOTFOUND;
          state_d  = S_DONE;
        end else if (more_q) begin
          rv_d = 1'b1;
          la_d = ptr_q;
          if ({1'b0, ptr_q} == last_idx) begin
            more_d = 1'b0;
          end else begin
            ptr_d = ptr_q + bdle_pkg::IDX_W'(1);
          end
        end else begin
          rv_d = 1'b0;
        end
      end

      // Shift entries p..count-1 up by one, tail first.
      S_UP: begin
        if (rv_q) begin
          we = 1'b1;
          wa = la_q + bdle_pkg::IDX_W'(1);
          wd = rdata_q;
        end
        if (more_q) begin
          rv_d = 1'b1;
          la_d = ptr_q;
          if (ptr_q == p_q) begin
            more_d = 1'b0;
          end else begin
            ptr_d = ptr_q - bdle_pkg::IDX_W'(1);
          end
        end else begin
          rv_d = 1'b0;
          if (rv_q) begin
            state_d = S_WR;
          end
        end
      end

      // Shift entries above the removed one down by one, head first.
      S_DN: begin
        if (rv_q) begin
          we = 1'b1;
          wa = la_q - bdle_pkg::IDX_W'(1);
          wd = rdata_q;
        end
        if (more_q) begin
          rv_d = 1'b1;
          la_d = ptr_q;
          if ({1'b0, ptr_q} == last_idx) begin
            more_d = 1'b0;
          end else begin
            ptr_d = ptr_q + bdle_pkg::IDX_W'(1);
          end
        end else begin
          rv_d = 1'b0;
          if (rv_q) begin
            count_d = last_idx;
            state_d = S_DONE;
          end
        end
      end

      // Place the new entry.
      S_WR: begin
        we      = 1'b1;
        wa      = p_q;
        wd      = val_q;
        count_d = count_q + bdle_pkg::CNT_W'(1);
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      more_q      <= 1'b0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      more_q  <= more_d;
      rv_q    <= rv_d;
      if ((state_q == S_DONE) && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    la_q     <= la_d;
    op_q     <= op_d;
    val_q    <= val_d;
    p_q      <= p_d;
    status_q <= status_d;
    popped_q <= popped_d;
    if ((state_q == S_DONE) && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {(count_q == '0), count_q, popped_q, status_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Bounded deque list engine testbench
// Drives operation beats into the engine, predicts each result beat from a
// behavioral list model held in a scoreboard, and compares field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode with no operation behind it.
  localparam logic [2:0] OP_NONE = 3'd7;

  // Expected result of one operation.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] popped;
    logic [4:0]  count;
    logic        empty;
  } list_result_t;

  // Scoreboard: behavioral list plus a queue of pending results.
  class list_scoreboard;
    logic [31:0]  entries[$];
    list_result_t pending[$];
    int           mismatches;

    function void note_operation(logic [2:0] op, logic [31:0] val, logic [7:0] pos);
      list_result_t r;
      int           idx;
      r.status = bdle_pkg::ST_OK;
      r.popped = '0;
      case (op)
        bdle_pkg::OP_PREPEND, bdle_pkg::OP_APPEND, bdle_pkg::OP_INS_AT: begin
          if (entries.size() >= bdle_pkg::CAPACITY) begin
            r.status = bdle_pkg::ST_FULL;
          end else if (op == bdle_pkg::OP_PREPEND) begin
            entries.push_front(val);
          end else if (op == bdle_pkg::OP_APPEND || pos >= entries.size()) begin
            entries.push_back(val);
          end else begin
            entries.insert(pos, val);
          end
        end
        bdle_pkg::OP_POP_HEAD, bdle_pkg::OP_POP_TAIL: begin
          if (entries.size() == 0) begin
            r.status = bdle_pkg::ST_EMPTY;
          end else if (op == bdle_pkg::OP_POP_HEAD) begin
            r.popped = entries.pop_front();
          end else begin
            r.popped = entries.pop_back();
          end
        end
        bdle_pkg::OP_DEL_AT: begin
          if (pos < entries.size()) begin
            entries.delete(pos);
          end else begin
            r.status = bdle_pkg::ST_NOTFOUND;
          end
        end
        bdle_pkg::OP_DEL_VAL: begin
          idx = -1;
          foreach (entries[i]) begin
            if (idx < 0 && entries[i] == val) idx = i;
          end
          if (idx >= 0) begin
            entries.delete(idx);
          end else begin
            r.status = bdle_pkg::ST_NOTFOUND;
          end
        end
        default: ;
      endcase
      r.count = 5'(entries.size());
      r.empty = (entries.size() == 0);
      pending.push_back(r);
    endfunction

    function void check_result(logic [39:0] data);
      list_result_t got;
      list_result_t want;
      got.status = data[1:0];
      got.popped = data[33:2];
      got.count  = data[38:34];
      got.empty  = data[39];
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %h", data);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch: status %0d/%0d popped %h/%h count %0d/%0d empty %0b/%0b",
                   want.status, got.status, want.popped, got.popped,
                   want.count, got.count, want.empty, got.empty);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  list_scoreboard list_sb;
  bit             stimulus_done;
  int             sink_hold;
  bit             long_hold_req;
  bit             long_hold_done;

  bounded_deque_list_engine i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one beat and note it in the scoreboard when accepted.
  task automatic send_op(logic [2:0] op, logic [31:0] val, logic [7:0] pos, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, pos, val, op};
    do @(posedge clk_i); while (!s_axis_tready);
    list_sb.note_operation(op, val, pos);
  endtask

  // Random 32-bit value, often drawn from a small pool so deletes hit.
  function automatic logic [31:0] rand_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return $urandom_range(0, 7);
    if (roll == 5) return {1'b1, 31'd0};
    if (roll == 6) return 32'h7fff_ffff;
    return $urandom();
  endfunction

  // Random operation; the mix drifts toward fill or drain to reach both ends.
  task automatic random_op(bit fill);
    logic [2:0] op;
    logic [7:0] pos;
    int         roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) op = OP_NONE;
    else if (fill) op = (roll < 60) ?
                        3'($urandom_range(bdle_pkg::OP_PREPEND, bdle_pkg::OP_APPEND)) :
                        (roll < 80) ? bdle_pkg::OP_INS_AT :
                        3'($urandom_range(bdle_pkg::OP_POP_HEAD, bdle_pkg::OP_DEL_VAL));
    else op = (roll < 30) ?
              3'($urandom_range(bdle_pkg::OP_PREPEND, bdle_pkg::OP_APPEND)) :
              (roll < 40) ? bdle_pkg::OP_INS_AT :
              3'($urandom_range(bdle_pkg::OP_POP_HEAD, bdle_pkg::OP_DEL_VAL));
    pos = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 17)) : 8'($urandom());
    send_op(op, rand_value(), pos, 1'b1);
  endtask

  // Result sink: random stalls, plus one long hold to back up the engine.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready  <= 1'b0;
      sink_hold      <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) list_sb.check_result(m_axis_tdata);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        sink_hold      <= 300;
        m_axis_tready  <= 1'b0;
      end else if (sink_hold > 0) begin
        sink_hold     <= sink_hold - 1;
        m_axis_tready <= 1'b0;
      end else if (!m_axis_tready && $urandom_range(0, 99) < 8) begin
        sink_hold     <= gap_len();
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) < 75);
      end
    end
  end

  // Stimulus.
  initial begin
    list_sb       = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pops, misses, fill to full, rejects, extremes.
    send_op(bdle_pkg::OP_POP_HEAD, 32'd0, 8'd0, 1'b0);
    send_op(bdle_pkg::OP_POP_TAIL, 32'd0, 8'd0, 1'b0);
    send_op(bdle_pkg::OP_DEL_AT, 32'd0, 8'd0, 1'b0);
    send_op(bdle_pkg::OP_DEL_VAL, 32'd5, 8'd0, 1'b0);
    send_op(bdle_pkg::OP_APPEND, 32'h8000_0000, 8'd0, 1'b0);
    send_op(bdle_pkg::OP_PREPEND, 32'h7fff_ffff, 8'd0, 1'b0);
    send_op(bdle_pkg::OP_INS_AT, 32'hffff_ffff, 8'd1, 1'b0);
    send_op(bdle_pkg::OP_INS_AT, 32'h5555_aaaa, 8'd255, 1'b0);
    send_op(OP_NONE, 32'hffff_ffff, 8'hff, 1'b0);
    for (int i = 0; i < 12; i++) send_op(bdle_pkg::OP_INS_AT, 32'(i), 8'(i * 3), 1'b0);
    send_op(bdle_pkg::OP_APPEND, 32'd1, 8'd0, 1'b0);
    send_op(bdle_pkg::OP_PREPEND, 32'd1, 8'd0, 1'b0);
    send_op(bdle_pkg::OP_DEL_AT, 32'd0, 8'd16, 1'b0);
    send_op(bdle_pkg::OP_DEL_AT, 32'd0, 8'd15, 1'b0);
    send_op(bdle_pkg::OP_DEL_VAL, 32'h8000_0000, 8'd0, 1'b0);
    send_op(bdle_pkg::OP_POP_HEAD, 32'd0, 8'd0, 1'b0);
    send_op(bdle_pkg::OP_POP_TAIL, 32'd0, 8'd0, 1'b0);

    // Long receiver hold while the sender keeps offering beats.
    long_hold_req = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_op(3'($urandom_range(bdle_pkg::OP_PREPEND, bdle_pkg::OP_DEL_VAL)),
              rand_value(), 8'($urandom_range(0, 20)), 1'b0);
    end

    // Random phases alternating between filling and draining.
    for (int p = 0; p < 18; p++) begin
      for (int i = 0; i < 47; i++) random_op(p[0] == 1'b0);
    end
    s_axis_tvalid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Drain and finish.
  initial begin
    wait (stimulus_done);
    while (list_sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (list_sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
